[rtl/core/spq_pkg.sv]
// Shared constants and types for the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

   localparam int QUEUE_DEPTH    = 16;
   localparam int DATA_WIDTH     = 32;
   localparam int PRIORITY_WIDTH = 16;
   localparam int COUNT_WIDTH    = $clog2(QUEUE_DEPTH + 1);
   localparam int FILL_WIDTH     = 5;
   localparam int STATUS_WIDTH   = 2;

   localparam logic REQ_ENQUEUE = 1'b0;
   localparam logic REQ_DEQUEUE = 1'b1;

   localparam logic [STATUS_WIDTH-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL  = 2'd2;

   // Controller to datapath.
   typedef struct packed {
      logic load;   // capture the request fields
      logic exec;   // apply the captured request, load the result register
   } spq_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic full;
      logic empty;
   } spq_stat_type;

endpackage

[rtl/core/spq_ctrl.sv]
// Controller state machine: request acceptance and result handshake.
`timescale 1ns / 1ps

module spq_ctrl
   import spq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  spq_stat_type stat,
   output spq_cmd_type  cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   // Output slot must be free by the exec cycle; nothing is taken in reset.
   assign req_ready = !reset && (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   assign cmd.load = accept;
   assign cmd.exec = (state_ff == ST_EXEC);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Status flags are observed by the top-level checks only.
   logic unused_stat;
   assign unused_stat = stat.full ^ stat.empty;

endmodule

[rtl/core/spq_dpath.sv]
// Datapath: sorted shift-register slot array, request capture and result register.
`timescale 1ns / 1ps

module spq_dpath
   import spq_pkg::*;
(
   input  logic                             clock,
   input  logic                             reset,
   input  spq_cmd_type                      cmd,
   output spq_stat_type                     stat,
   input  logic                             req_type,
   input  logic signed [DATA_WIDTH-1:0]     req_item_data,
   input  logic signed [PRIORITY_WIDTH-1:0] req_item_priority,
   output logic        [STATUS_WIDTH-1:0]   rsp_status,
   output logic signed [DATA_WIDTH-1:0]     rsp_out_data,
   output logic signed [PRIORITY_WIDTH-1:0] rsp_out_priority,
   output logic        [FILL_WIDTH-1:0]     rsp_fill_level
);

   logic signed [DATA_WIDTH-1:0]     slot_data_ff [QUEUE_DEPTH];
   logic signed [DATA_WIDTH-1:0]     slot_data_in [QUEUE_DEPTH];
   logic signed [PRIORITY_WIDTH-1:0] slot_prio_ff [QUEUE_DEPTH];
   logic signed [PRIORITY_WIDTH-1:0] slot_prio_in [QUEUE_DEPTH];
   logic        [COUNT_WIDTH-1:0]    count_ff, count_in;

   logic                             op_ff;
   logic signed [DATA_WIDTH-1:0]     op_data_ff;
   logic signed [PRIORITY_WIDTH-1:0] op_prio_ff;

   logic        [STATUS_WIDTH-1:0]   status_ff, status_in;
   logic signed [DATA_WIDTH-1:0]     out_data_ff, out_data_in;
   logic signed [PRIORITY_WIDTH-1:0] out_prio_ff, out_prio_in;
   logic        [FILL_WIDTH-1:0]     fill_ff;

   logic [QUEUE_DEPTH-1:0] keep;   // held slot stays ahead of the new entry
   logic                   full, empty;

   assign full  = (count_ff == COUNT_WIDTH'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign stat.full  = full;
   assign stat.empty = empty;

   // Slots are sorted, so keep is a prefix of ones.
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         keep[i] = (COUNT_WIDTH'(i) < count_ff) && (slot_prio_ff[i] >= op_prio_ff);
      end
   end

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         slot_data_in[i] = slot_data_ff[i];
         slot_prio_in[i] = slot_prio_ff[i];
      end
      count_in    = count_ff;
      status_in   = STATUS_DONE;
      out_data_in = '0;
      out_prio_in = '0;
      if (op_ff == REQ_ENQUEUE) begin
         if (full) begin
            status_in = STATUS_FULL;
         end else begin
            count_in = count_ff + 1'b1;
            if (!keep[0]) begin
               slot_data_in[0] = op_data_ff;
               slot_prio_in[0] = op_prio_ff;
            end
            for (int i = 1; i < QUEUE_DEPTH; i++) begin
               if (!keep[i]) begin
                  if (keep[i-1]) begin
                     slot_data_in[i] = op_data_ff;
                     slot_prio_in[i] = op_prio_ff;
                  end else begin
                     slot_data_in[i] = slot_data_ff[i-1];
                     slot_prio_in[i] = slot_prio_ff[i-1];
                  end
               end
            end
         end
      end else begin
         if (empty) begin
            status_in = STATUS_EMPTY;
         end else begin
            count_in    = count_ff - 1'b1;
            out_data_in = slot_data_ff[0];
            out_prio_in = slot_prio_ff[0];
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
               slot_data_in[i] = slot_data_ff[i+1];
               slot_prio_in[i] = slot_prio_ff[i+1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= req_type;
         op_data_ff <= req_item_data;
         op_prio_ff <= req_item_priority;
      end
      if (cmd.exec) begin
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            slot_data_ff[i] <= slot_data_in[i];
            slot_prio_ff[i] <= slot_prio_in[i];
         end
         status_ff   <= status_in;
         out_data_ff <= out_data_in;
         out_prio_ff <= out_prio_in;
         fill_ff     <= FILL_WIDTH'(count_in);
      end
   end

   assign rsp_status       = status_ff;
   assign rsp_out_data     = out_data_ff;
   assign rsp_out_priority = out_prio_ff;
   assign rsp_fill_level   = fill_ff;

endmodule

[rtl/core/sorted_priority_queue_unit.sv]
// Top level of the sorted priority queue: controller, datapath and checks.
// Result valid is registered after the exec state of an accepted request.
// No request is taken while another executes, as the capture/exec sequence
//   of the controller runs around the single slot array update.
// Reset (synchronous, active high) empties the queue and drops any pending
//   result; slot contents are not cleared and are never read while unused.
`timescale 1ns / 1ps

module sorted_priority_queue_unit
   import spq_pkg::*;
(
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_type,
   input  logic signed [DATA_WIDTH-1:0]     req_item_data,
   input  logic signed [PRIORITY_WIDTH-1:0] req_item_priority,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic        [STATUS_WIDTH-1:0]   rsp_status,
   output logic signed [DATA_WIDTH-1:0]     rsp_out_data,
   output logic signed [PRIORITY_WIDTH-1:0] rsp_out_priority,
   output logic        [FILL_WIDTH-1:0]     rsp_fill_level
);

   // Command and status between controller and datapath.
   spq_cmd_type  cmd;
   spq_stat_type stat;

   // Controller: accepts a transaction only when the result register will
   // be free by the exec cycle, so a waiting result never gets overwritten.
   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: slot 0 is the head; enqueue inserts behind all entries of
   // greater or equal priority (FIFO among ties), dequeue shifts up.
   spq_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_type          (req_type),
      .req_item_data     (req_item_data),
      .req_item_priority (req_item_priority),
      .rsp_status        (rsp_status),
      .rsp_out_data      (rsp_out_data),
      .rsp_out_priority  (rsp_out_priority),
      .rsp_fill_level    (rsp_fill_level)
   );

`ifndef NO_ASSERTIONS
   // One transaction in flight: no new accept right after an accept.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while previous one executing");

   // Every accepted transaction yields a result after its exec state.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> ##2 rsp_valid)
      else $error("result missing after accepted request");

   // Full rejection only when the queue is at depth.
   a_full_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_FULL) |->
         (rsp_fill_level == FILL_WIDTH'(QUEUE_DEPTH)))
      else $error("full status with queue not at depth");

   // Empty status only with nothing held; empty flag tracks that.
   a_empty_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_EMPTY) |->
         (rsp_fill_level == '0 && stat.empty && !stat.full))
      else $error("empty status with entries held");
`endif

endmodule

[tb/sv/spq_tb_pkg.sv]
// Result predictor and checker for the sorted priority queue testbench.
`timescale 1ns / 1ps

package spq_tb_pkg;

   import spq_pkg::*;

   typedef struct {
      logic        [STATUS_WIDTH-1:0]   status;
      logic signed [DATA_WIDTH-1:0]     data;
      logic signed [PRIORITY_WIDTH-1:0] prio;
      logic        [FILL_WIDTH-1:0]     fill;
   } spq_result_type;

   class spq_order_tracker;

      // Shadow of the queue contents, slot 0 is the head.
      logic signed [DATA_WIDTH-1:0]     shadow_data[QUEUE_DEPTH];
      logic signed [PRIORITY_WIDTH-1:0] shadow_prio[QUEUE_DEPTH];
      int unsigned                      held;

      spq_result_type expected_q[$];

      int unsigned errors;
      int unsigned enq_done;
      int unsigned deq_done;
      int unsigned full_hits;
      int unsigned empty_hits;
      int unsigned peak_fill;
      int unsigned results_checked;

      function new();
         held            = 0;
         errors          = 0;
         enq_done        = 0;
         deq_done        = 0;
         full_hits       = 0;
         empty_hits      = 0;
         peak_fill       = 0;
         results_checked = 0;
      endfunction

      // Apply one accepted request to the shadow queue and queue its result.
      function void note_request(logic kind, logic signed [DATA_WIDTH-1:0] data,
                                 logic signed [PRIORITY_WIDTH-1:0] prio);
         spq_result_type r;
         int unsigned pos;
         r.status = STATUS_DONE;
         r.data   = '0;
         r.prio   = '0;
         if (kind == REQ_ENQUEUE) begin
            if (held >= QUEUE_DEPTH) begin
               r.status = STATUS_FULL;
               full_hits++;
            end else begin
               // new entry goes behind everything of equal or higher priority
               pos = 0;
               while (pos < held && shadow_prio[pos] >= prio) pos++;
               for (int i = held; i > pos; i--) begin
                  shadow_data[i] = shadow_data[i-1];
                  shadow_prio[i] = shadow_prio[i-1];
               end
               shadow_data[pos] = data;
               shadow_prio[pos] = prio;
               held++;
               enq_done++;
               if (held > peak_fill) peak_fill = held;
            end
         end else begin
            if (held == 0) begin
               r.status = STATUS_EMPTY;
               empty_hits++;
            end else begin
               r.data = shadow_data[0];
               r.prio = shadow_prio[0];
               for (int i = 1; i < held; i++) begin
                  shadow_data[i-1] = shadow_data[i];
                  shadow_prio[i-1] = shadow_prio[i];
               end
               held--;
               deq_done++;
            end
         end
         r.fill = FILL_WIDTH'(held);
         expected_q.push_back(r);
      endfunction

      function void check_result(spq_result_type got);
         spq_result_type want;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: result with nothing outstanding: status %0d data %0d prio %0d fill %0d",
                     $time, got.status, got.data, got.prio, got.fill);
            return;
         end
         want = expected_q.pop_front();
         results_checked++;
         if (got.status !== want.status) begin
            errors++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, got.status);
         end
         if (got.data !== want.data) begin
            errors++;
            $display("%0t: out_data mismatch: expected %0d, actual %0d",
                     $time, want.data, got.data);
         end
         if (got.prio !== want.prio) begin
            errors++;
            $display("%0t: out_priority mismatch: expected %0d, actual %0d",
                     $time, want.prio, got.prio);
         end
         if (got.fill !== want.fill) begin
            errors++;
            $display("%0t: fill_level mismatch: expected %0d, actual %0d",
                     $time, want.fill, got.fill);
         end
      endfunction

      function int unsigned outstanding();
         return expected_q.size();
      endfunction

   endclass

endpackage

[tb/sv/tb_top.sv]
// Top-level testbench for sorted_priority_queue_unit: stimulus, handshakes and checking.
`timescale 1ns / 1ps

module tb_top;

   import spq_pkg::*;
   import spq_tb_pkg::*;

   localparam int RANDOM_ITEMS     = 1000;
   localparam int LONG_HOLD_CYCLES = 250;
   localparam int DRAIN_CYCLES     = 20;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // Request side
   logic                             req_valid         = 1'b0;
   logic                             req_ready;
   logic                             req_type          = REQ_ENQUEUE;
   logic signed [DATA_WIDTH-1:0]     req_item_data     = '0;
   logic signed [PRIORITY_WIDTH-1:0] req_item_priority = '0;

   // Response side
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic        [STATUS_WIDTH-1:0]   rsp_status;
   logic signed [DATA_WIDTH-1:0]     rsp_out_data;
   logic signed [PRIORITY_WIDTH-1:0] rsp_out_priority;
   logic        [FILL_WIDTH-1:0]     rsp_fill_level;

   spq_order_tracker tracker = new();

   // Idle odds in percent, per request (tx) or per cycle (rx), set per phase.
   int unsigned tx_idle_pct   = 0;
   int unsigned rx_idle_pct   = 0;
   // Set by the sequencer, consumed by the response process: long back-pressure.
   bit          long_hold_req = 1'b0;
   int unsigned requests_sent = 0;

   sorted_priority_queue_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_item_data     (req_item_data),
      .req_item_priority (req_item_priority),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_out_data      (rsp_out_data),
      .rsp_out_priority  (rsp_out_priority),
      .rsp_fill_level    (rsp_fill_level)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Run limit; well above the slowest legal run (all gaps long, repeated
   // long holds on the response side).
   initial begin
      #2_000_000;
      $display("sorted_priority_queue_unit test failed");
      $finish;
   end

   // Idle length: a short gap nine times in ten, else a long one.
   function automatic int unsigned idle_length();
      if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic int unsigned idle_gap(int unsigned pct);
      if ($urandom_range(0, 99) >= pct) return 0;
      return idle_length();
   endfunction

   function automatic int unsigned pick_idle_pct();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 15;
         2: return 40;
         default: return 70;
      endcase
   endfunction

   // Mix of full-range values, a narrow band (lots of ties, exercises FIFO
   // order among equals) and the signed extremes.
   function automatic logic signed [PRIORITY_WIDTH-1:0] pick_priority();
      case ($urandom_range(0, 3))
         0: return PRIORITY_WIDTH'($urandom_range(0, 6)) - PRIORITY_WIDTH'(3);
         1: begin
            case ($urandom_range(0, 3))
               0: return {1'b0, {(PRIORITY_WIDTH-1){1'b1}}};
               1: return {1'b1, {(PRIORITY_WIDTH-1){1'b0}}};
               2: return '0;
               default: return '1;
            endcase
         end
         default: return PRIORITY_WIDTH'($urandom);
      endcase
   endfunction

   // Offer one request and hold it until the block accepts it. The
   // valid is only lowered when a gap is taken, so back-to-back requests
   // keep it high without a second assignment in the same step.
   task automatic send_request(input logic kind,
                               input logic signed [DATA_WIDTH-1:0] data,
                               input logic signed [PRIORITY_WIDTH-1:0] prio);
      int unsigned gap;
      gap = idle_gap(tx_idle_pct);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_type          <= kind;
      req_item_data     <= data;
      req_item_priority <= prio;
      do @(posedge clock); while (!req_ready);
      tracker.note_request(kind, data, prio);
      requests_sent++;
   endtask

   // Response side: check each completed transaction, then pick next ready.
   initial begin
      spq_result_type got;
      int unsigned rx_hold;
      rx_hold = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            got.status = rsp_status;
            got.data   = rsp_out_data;
            got.prio   = rsp_out_priority;
            got.fill   = rsp_fill_level;
            tracker.check_result(got);
         end
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rx_hold       = LONG_HOLD_CYCLES;
         end
         if (rx_hold == 0 && $urandom_range(0, 99) < rx_idle_pct) rx_hold = idle_length();
         if (rx_hold > 0) begin
            rsp_ready <= 1'b0;
            rx_hold--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Sequencer: reset, directed cases, random phases, drain, verdict.
   initial begin
      int unsigned random_sent;
      int unsigned phase;
      int unsigned phase_len;
      int unsigned enq_pct;
      logic        kind;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty dequeue, signed extremes, ties, then drain past empty.
      tx_idle_pct = 0;
      rx_idle_pct = 30;
      send_request(REQ_DEQUEUE, 32'sh1357_9bdf, 16'sh2468);
      send_request(REQ_ENQUEUE, 32'sh7fff_ffff, 16'sh7fff);
      send_request(REQ_ENQUEUE, 32'sh8000_0000, 16'sh8000);
      send_request(REQ_ENQUEUE, 32'sh0000_0000, 16'sh0000);
      send_request(REQ_ENQUEUE, 32'shffff_ffff, 16'shffff);
      send_request(REQ_ENQUEUE, 32'sh0000_5a5a, 16'sh0005);
      send_request(REQ_ENQUEUE, 32'sha5a5_0000, 16'sh0005);
      send_request(REQ_ENQUEUE, 32'sh0f0f_0f0f, 16'sh0005);
      // tie with the maximum: must come out behind the first one
      send_request(REQ_ENQUEUE, 32'sh0000_0001, 16'sh7fff);
      repeat (9) send_request(REQ_DEQUEUE, 32'(($urandom)), PRIORITY_WIDTH'($urandom));

      // Random phases. Each phase leans toward filling, draining or balance;
      // two phases add a long response stall with the request side flat out,
      // so the block backs up and drops req_ready.
      random_sent = 0;
      phase       = 0;
      while (random_sent < RANDOM_ITEMS) begin
         phase_len = $urandom_range(20, 80);
         case ($urandom_range(0, 3))
            0: enq_pct = 85;
            1: enq_pct = 15;
            default: enq_pct = 55;
         endcase
         tx_idle_pct = pick_idle_pct();
         rx_idle_pct = pick_idle_pct();
         if (phase == 1 || phase == 7) begin
            enq_pct       = 60;
            tx_idle_pct   = 0;
            long_hold_req = 1'b1;
         end
         repeat (phase_len) begin
            kind = ($urandom_range(0, 99) < enq_pct) ? REQ_ENQUEUE : REQ_DEQUEUE;
            send_request(kind, 32'($urandom), pick_priority());
            random_sent++;
         end
         phase++;
      end

      req_valid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      // catch any stray result after the last expected one
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests: %0d entries stored, %0d served, %0d refused when full, %0d empty",
               requests_sent, tracker.enq_done, tracker.deq_done, tracker.full_hits,
               tracker.empty_hits);
      $display("peak fill %0d of %0d, %0d results checked, %0d mismatches",
               tracker.peak_fill, QUEUE_DEPTH, tracker.results_checked, tracker.errors);
      if (tracker.errors == 0) begin
         $display("sorted_priority_queue_unit test passed");
      end else begin
         $display("sorted_priority_queue_unit test failed");
      end
      $finish;
   end

endmodule
